>>> sv/heat_station_supply_controller_defines.svh
// Assertion helpers for the supply controller sources.
`ifndef HEAT_STATION_SUPPLY_CONTROLLER_DEFINES_SVH
`define HEAT_STATION_SUPPLY_CONTROLLER_DEFINES_SVH

// Implication in the same cycle, checked on every rising clock edge outside reset.
`define HSCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication into the following cycle.
`define HSCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/hscs_pkg.sv
`timescale 1ns / 1ps

package hscs_pkg;

  localparam logic [2:0] MODE_POWER_ON   = 3'd0;
  localparam logic [2:0] MODE_SELF_CHECK = 3'd1;
  localparam logic [2:0] MODE_STANDBY    = 3'd2;
  localparam logic [2:0] MODE_STARTING   = 3'd3;
  localparam logic [2:0] MODE_RUNNING    = 3'd4;
  localparam logic [2:0] MODE_ALARM      = 3'd5;
  localparam logic [2:0] MODE_ESTOP      = 3'd6;

  localparam logic [2:0] CAUSE_NONE          = 3'd0;
  localparam logic [2:0] CAUSE_SENSOR_FAULT  = 3'd1;
  localparam logic [2:0] CAUSE_OVER_TEMP     = 3'd2;
  localparam logic [2:0] CAUSE_HIGH_PRESSURE = 3'd3;
  localparam logic [2:0] CAUSE_LOW_PRESSURE  = 3'd4;

  localparam logic [2:0] REG_TARGET_SUPPLY_TEMP   = 3'd0;
  localparam logic [2:0] REG_TARGET_DIFF_PRESSURE = 3'd1;
  localparam logic [2:0] REG_OVER_TEMP_LIMIT      = 3'd2;
  localparam logic [2:0] REG_HIGH_PRESSURE_LIMIT  = 3'd3;
  localparam logic [2:0] REG_LOW_PRESSURE_LIMIT   = 3'd4;
  localparam logic [2:0] REG_REFILL_STOP_PRESSURE = 3'd5;
  localparam logic [2:0] REG_START_DELAY_TICKS    = 3'd6;

  localparam int CFG_DATA_W = 12;

  localparam logic [11:0] RST_TARGET_SUPPLY_TEMP   = 12'd450;
  localparam logic [10:0] RST_TARGET_DIFF_PRESSURE = 11'd80;
  localparam logic [11:0] RST_OVER_TEMP_LIMIT      = 12'd650;
  localparam logic [10:0] RST_HIGH_PRESSURE_LIMIT  = 11'd600;
  localparam logic [10:0] RST_LOW_PRESSURE_LIMIT   = 11'd120;
  localparam logic [10:0] RST_REFILL_STOP_PRESSURE = 11'd250;
  localparam logic [7:0]  RST_START_DELAY_TICKS    = 8'd3;

  localparam logic [6:0] RST_VALVE = 7'd18;
  localparam logic [5:0] RST_FREQ  = 6'd30;

  localparam logic [7:0] TICK_MAX    = 8'd255;
  localparam logic [6:0] VALVE_MAX   = 7'd100;
  localparam logic [6:0] START_VALVE = 7'd10;
  localparam logic [5:0] FREQ_MIN    = 6'd20;
  localparam logic [5:0] FREQ_MAX    = 6'd50;
  localparam logic [5:0] START_FREQ  = 6'd28;

  localparam logic signed [12:0] DEADBAND     = 13'sd10;
  localparam logic signed [12:0] DEADBAND_NEG = -13'sd10;

  typedef struct packed {
    logic signed [11:0] supply_temp;
    logic [10:0]        supply_pressure;
    logic [10:0]        return_pressure;
    logic               temp_sensor_good;
    logic               pressure_sensor_good;
  } sample_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] valve_percent;
    logic [5:0] pump_freq_hz;
    logic       pump_on;
    logic       refill_on;
    logic       alarm_on;
    logic [2:0] alarm_cause;
  } result_t;

  typedef struct packed {
    logic signed [11:0] target_supply_temp;
    logic [10:0]        target_diff_pressure;
    logic signed [11:0] over_temp_limit;
    logic [10:0]        high_pressure_limit;
    logic [10:0]        low_pressure_limit;
    logic [10:0]        refill_stop_pressure;
    logic [7:0]         start_delay_ticks;
  } hscs_cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] tick;
    logic [6:0] valve;
    logic [5:0] freq;
    logic       pump;
    logic       refill;
  } hscs_state_t;

endpackage

>>> sv/hscs_step.sv
`timescale 1ns / 1ps

module hscs_step import hscs_pkg::*; (
  input  hscs_state_t cur,
  input  hscs_cfg_t   cfg,
  input  sample_t     smp,
  output hscs_state_t nxt,
  output result_t     res
);

  logic                alarm;
  logic [2:0]          cause;
  logic                estop;
  logic                regulate;
  logic signed [12:0]  terr;
  logic signed [11:0]  dp;
  logic signed [12:0]  perr;
  logic signed [8:0]   valve_sum;
  logic signed [7:0]   freq_sum;
  hscs_state_t         seq;

  assign terr = {cfg.target_supply_temp[11], cfg.target_supply_temp}
              - {smp.supply_temp[11], smp.supply_temp};
  assign dp   = {1'b0, smp.supply_pressure} - {1'b0, smp.return_pressure};
  assign perr = {2'b00, cfg.target_diff_pressure} - {dp[11], dp};

  always_comb begin
    seq = cur;
    case (cur.mode)
      MODE_POWER_ON: begin
        seq.mode = MODE_SELF_CHECK;
      end
      MODE_SELF_CHECK: begin
        seq.mode = MODE_STANDBY;
      end
      MODE_STANDBY: begin
        if (cur.tick >= cfg.start_delay_ticks) begin
          seq.mode = MODE_STARTING;
        end
      end
      MODE_STARTING: begin
        seq.pump  = 1'b1;
        seq.freq  = START_FREQ;
        seq.valve = START_VALVE;
        seq.mode  = MODE_RUNNING;
      end
      default: begin
        seq.mode = cur.mode;
      end
    endcase

    alarm = 1'b0;
    cause = CAUSE_NONE;
    estop = 1'b0;
    if (!smp.temp_sensor_good || !smp.pressure_sensor_good) begin
      seq.mode   = MODE_ESTOP;
      seq.valve  = '0;
      seq.pump   = 1'b0;
      seq.refill = 1'b0;
      alarm      = 1'b1;
      cause      = CAUSE_SENSOR_FAULT;
      estop      = 1'b1;
    end else if (smp.supply_temp >= cfg.over_temp_limit) begin
      seq.mode   = MODE_ESTOP;
      seq.valve  = '0;
      seq.pump   = 1'b1;
      seq.refill = 1'b0;
      alarm      = 1'b1;
      cause      = CAUSE_OVER_TEMP;
      estop      = 1'b1;
    end else if (smp.supply_pressure >= cfg.high_pressure_limit) begin
      seq.mode   = MODE_ESTOP;
      seq.valve  = '0;
      seq.freq   = FREQ_MIN;
      seq.refill = 1'b0;
      alarm      = 1'b1;
      cause      = CAUSE_HIGH_PRESSURE;
      estop      = 1'b1;
    end else if (smp.return_pressure <= cfg.low_pressure_limit) begin
      seq.mode   = MODE_ALARM;
      seq.refill = 1'b1;
      alarm      = 1'b1;
      cause      = CAUSE_LOW_PRESSURE;
    end

    regulate = !estop && (seq.mode == MODE_RUNNING || seq.mode == MODE_ALARM);

    if (terr > DEADBAND) begin
      valve_sum = $signed({2'b00, seq.valve}) + 9'sd2;
    end else if (terr < DEADBAND_NEG) begin
      valve_sum = $signed({2'b00, seq.valve}) - 9'sd2;
    end else begin
      valve_sum = $signed({2'b00, seq.valve});
    end

    if (perr > DEADBAND) begin
      freq_sum = $signed({2'b00, seq.freq}) + 8'sd1;
    end else if (perr < DEADBAND_NEG) begin
      freq_sum = $signed({2'b00, seq.freq}) - 8'sd1;
    end else begin
      freq_sum = $signed({2'b00, seq.freq});
    end

    nxt = seq;
    if (regulate) begin
      if (valve_sum < 9'sd0) begin
        nxt.valve = '0;
      end else if (valve_sum > $signed({2'b00, VALVE_MAX})) begin
        nxt.valve = VALVE_MAX;
      end else begin
        nxt.valve = valve_sum[6:0];
      end
      if (freq_sum < $signed({2'b00, FREQ_MIN})) begin
        nxt.freq = FREQ_MIN;
      end else if (freq_sum > $signed({2'b00, FREQ_MAX})) begin
        nxt.freq = FREQ_MAX;
      end else begin
        nxt.freq = freq_sum[5:0];
      end
      if (smp.return_pressure >= cfg.refill_stop_pressure) begin
        nxt.refill = 1'b0;
      end
    end

    if (cur.tick != TICK_MAX) begin
      nxt.tick = cur.tick + 8'd1;
    end
  end

  assign res.mode          = nxt.mode;
  assign res.valve_percent = nxt.valve;
  assign res.pump_freq_hz  = nxt.freq;
  assign res.pump_on       = nxt.pump;
  assign res.refill_on     = nxt.refill;
  assign res.alarm_on      = alarm;
  assign res.alarm_cause   = cause;

endmodule

>>> sv/heat_station_supply_controller.sv
// Secondary-loop supply controller for a heat station, one sensor sample per control tick.
// Input channel in_valid/in_ready/in_data carries one sample: supply temperature,
// supply and return pressures and two sensor health flags. Output channel
// out_valid/out_ready/out_data carries one result per sample: mode, valve opening,
// pump frequency, pump and refill commands, alarm flag and alarm cause.
// Limits and targets are written through cfg_we/cfg_index/cfg_wdata; the user must do so
// only while the block is idle, which the block itself does not enforce. A sample is held in
// an input register, then the whole tick is evaluated by one combinational pass that updates
// the controller state and loads the result register. The sample passes through the input
// register and then the result register before its result can transfer at the output.
// Throughput is one sample per cycle while out_ready stays high; the input register
// and the result register each advance whenever the stage after them is empty or is transferring.
// When the receiver stalls, the result register holds and the input register fills,
// after which in_ready drops until the output transfer happens.
// Reset clears both valid flags, puts the mode at power on with tick zero, valve 18 %,
// pump 30 Hz and pump and refill off, and restores every configuration register.
`timescale 1ns / 1ps
`include "heat_station_supply_controller_defines.svh"

module heat_station_supply_controller import hscs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sample_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output result_t               out_data,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  hscs_cfg_t   cfg;
  hscs_state_t st;
  hscs_state_t st_next;
  result_t     res_next;
  sample_t     s1_data;
  logic        s1_valid;
  logic        out_free;
  logic        s1_go;

  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_supply_temp   <= RST_TARGET_SUPPLY_TEMP;
      cfg.target_diff_pressure <= RST_TARGET_DIFF_PRESSURE;
      cfg.over_temp_limit      <= RST_OVER_TEMP_LIMIT;
      cfg.high_pressure_limit  <= RST_HIGH_PRESSURE_LIMIT;
      cfg.low_pressure_limit   <= RST_LOW_PRESSURE_LIMIT;
      cfg.refill_stop_pressure <= RST_REFILL_STOP_PRESSURE;
      cfg.start_delay_ticks    <= RST_START_DELAY_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_SUPPLY_TEMP:   cfg.target_supply_temp   <= cfg_wdata;
        REG_TARGET_DIFF_PRESSURE: cfg.target_diff_pressure <= cfg_wdata[10:0];
        REG_OVER_TEMP_LIMIT:      cfg.over_temp_limit      <= cfg_wdata;
        REG_HIGH_PRESSURE_LIMIT:  cfg.high_pressure_limit  <= cfg_wdata[10:0];
        REG_LOW_PRESSURE_LIMIT:   cfg.low_pressure_limit   <= cfg_wdata[10:0];
        REG_REFILL_STOP_PRESSURE: cfg.refill_stop_pressure <= cfg_wdata[10:0];
        REG_START_DELAY_TICKS:    cfg.start_delay_ticks    <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  hscs_step u_step (
    .cur (st),
    .cfg (cfg),
    .smp (s1_data),
    .nxt (st_next),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode   <= MODE_POWER_ON;
      st.tick   <= '0;
      st.valve  <= RST_VALVE;
      st.freq   <= RST_FREQ;
      st.pump   <= 1'b0;
      st.refill <= 1'b0;
    end else if (s1_go) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data <= res_next;
    end
  end

  `HSCS_ASSERT_NEXT(a_estop_sticky, st.mode == MODE_ESTOP, st.mode == MODE_ESTOP || st.mode == MODE_ALARM, "emergency stop was left for a mode other than alarm")
  `HSCS_ASSERT_NEXT(a_alarm_sticky, st.mode == MODE_ALARM, st.mode == MODE_ALARM || st.mode == MODE_ESTOP, "alarm mode was left without reset")
  `HSCS_ASSERT_NOW(a_valve_range, out_valid, out_data.valve_percent <= VALVE_MAX, "valve opening above full scale")
  `HSCS_ASSERT_NOW(a_run_freq, out_valid && out_data.mode == MODE_RUNNING, out_data.pump_freq_hz >= FREQ_MIN && out_data.pump_freq_hz <= FREQ_MAX, "running pump frequency out of band")
  `HSCS_ASSERT_NOW(a_cause_flag, out_valid, out_data.alarm_on == (out_data.alarm_cause != CAUSE_NONE), "alarm flag disagrees with alarm cause")
  `HSCS_ASSERT_NOW(a_stall_full, !in_ready, s1_valid && out_valid, "input stalled while a stage is empty")

endmodule
